FILE: hw/rtl/ssw_pkg.sv
// Shared types and constants for the subset-sum way counter.
// Holds the request and result payload structs and the controller/datapath links.
// No dependencies.
package ssw_pkg;

	localparam int MAX_SUM_DEF     = 255;
	localparam int COUNT_WIDTH_DEF = 32;

	localparam int VALUE_W  = 16;
	localparam int TARGET_W = 8;
	localparam int OUT_W    = 32;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	// register index of target_sum
	localparam logic [REG_IDX_W-1:0] REG_TARGET = REG_IDX_W'(0);

	typedef struct packed {
		logic [VALUE_W-1:0] item_value;
		logic               last_item;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] way_count;
		logic             count_saturated;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // latch item value and target, start index at target
		logic upd_rd;   // read j and j-v, step index down
		logic res_rd;   // read entry at target
		logic res_cap;  // load result register, rewind index, drop sticky flag
		logic clr_wr;   // write reset value at index, step down
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic skip;      // offered item exceeds the target
		logic upd_last;  // index has reached the item value
		logic clr_last;  // index has reached entry zero
		logic out_free;  // result register can take a new value
	} sts_t;

endpackage

FILE: hw/rtl/ssw_cfg.sv
// Configuration register file: APB-style write and read of target_sum.
// Depends on ssw_pkg.
module ssw_cfg
	import ssw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [TARGET_W-1:0] target
);

	logic [TARGET_W-1:0] target_q;
	logic                hit;

	assign hit    = (paddr[PADDR_W-1:2] == REG_TARGET);
	assign pready = 1'b1;
	assign prdata = hit ? PDATA_W'(target_q) : '0;
	assign target = target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (psel && penable && pwrite && pready && hit) begin
			target_q <= pwdata[TARGET_W-1:0];
		end
	end

endmodule

FILE: hw/rtl/ssw_ctrl.sv
// Sequencing controller: accepts requests, walks the table update, fetches
// the result and runs the clearing sweep. Depends on ssw_pkg.
module ssw_ctrl
	import ssw_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	input  logic item_last,
	output logic item_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_DRAIN,
		ST_RES_RD,
		ST_RES_CAP,
		ST_CLR
	} state_t;

	state_t state_q;
	logic   last_q;

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:    cmd.load    = item_valid;
			ST_UPD:     cmd.upd_rd  = 1'b1;
			ST_RES_RD:  cmd.res_rd  = 1'b1;
			ST_RES_CAP: cmd.res_cap = sts.out_free;
			ST_CLR:     cmd.clr_wr  = 1'b1;
			default:    cmd = '0;
		endcase
	end

	// memory holds garbage after reset, so start in the clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			last_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						last_q <= item_last;
						if (!sts.skip) begin
							state_q <= ST_UPD;
						end else if (item_last) begin
							state_q <= ST_RES_RD;
						end
					end
				end
				ST_UPD: begin
					if (sts.upd_last) begin
						state_q <= last_q ? ST_DRAIN : ST_IDLE;
					end
				end
				// let the final write land before reading the target entry
				ST_DRAIN:   state_q <= ST_RES_RD;
				ST_RES_RD:  state_q <= ST_RES_CAP;
				ST_RES_CAP: begin
					if (sts.out_free) begin
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					if (sts.clr_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/ssw_dp.sv
// Datapath: way-count memory, index counter, saturating adder, sticky
// saturation flag and result register. Depends on ssw_pkg.
module ssw_dp
	import ssw_pkg::*;
#(
	parameter int MAX_SUM     = MAX_SUM_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  item_t               item,
	input  logic [TARGET_W-1:0] target,
	input  logic                result_stall,
	output logic                result_valid,
	output result_t             result
);

	localparam int DEPTH = MAX_SUM + 1;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [VALUE_W-1:0] MAX_SUM_V = VALUE_W'(MAX_SUM);
	localparam logic [IDX_W-1:0]   TOP_IDX   = IDX_W'(MAX_SUM);

	logic [COUNT_WIDTH-1:0] mem [DEPTH];

	logic [VALUE_W-1:0]     t_wide;
	logic [IDX_W-1:0]       t_eff;
	logic [IDX_W-1:0]       t_q;
	logic [IDX_W-1:0]       v_q;
	logic [IDX_W-1:0]       j_q;
	logic [IDX_W-1:0]       addr_a;
	logic [IDX_W-1:0]       addr_b;
	logic [COUNT_WIDTH-1:0] rd_a_s1;
	logic [COUNT_WIDTH-1:0] rd_b_s1;
	logic [IDX_W-1:0]       wr_addr_s1;
	logic                   wr_en_s1;
	logic [COUNT_WIDTH:0]   sum;
	logic                   ovf;
	logic [COUNT_WIDTH-1:0] upd_data;
	logic                   wr_en;
	logic [IDX_W-1:0]       wr_addr;
	logic [COUNT_WIDTH-1:0] wr_data;
	logic                   sat_q;
	logic                   result_valid_q;
	result_t                result_q;
	logic [OUT_W-1:0]       clamped;

	// a target beyond the table behaves as the top entry
	assign t_wide = (VALUE_W'(target) > MAX_SUM_V) ? MAX_SUM_V : VALUE_W'(target);
	assign t_eff  = t_wide[IDX_W-1:0];

	assign sts.skip     = (item.item_value > t_wide);
	assign sts.upd_last = (j_q == v_q);
	assign sts.clr_last = (j_q == '0);
	assign sts.out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			j_q <= TOP_IDX;
		end else if (cmd.load) begin
			j_q <= t_eff;
		end else if (cmd.upd_rd || cmd.clr_wr) begin
			j_q <= j_q - IDX_W'(1);
		end else if (cmd.res_cap) begin
			j_q <= TOP_IDX;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= item.item_value[IDX_W-1:0];
			t_q <= t_eff;
		end
	end

	assign addr_a = cmd.res_rd ? t_q : j_q;
	assign addr_b = j_q - v_q;

	// saturating add on the registered read data
	assign sum      = {1'b0, rd_a_s1} + {1'b0, rd_b_s1};
	assign ovf      = sum[COUNT_WIDTH];
	assign upd_data = ovf ? '1 : sum[COUNT_WIDTH-1:0];

	assign wr_en   = wr_en_s1 || cmd.clr_wr;
	assign wr_addr = cmd.clr_wr ? j_q : wr_addr_s1;
	assign wr_data = cmd.clr_wr ? ((j_q == '0) ? COUNT_WIDTH'(1) : '0) : upd_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.upd_rd || cmd.res_rd) begin
			rd_a_s1 <= mem[addr_a];
		end
		if (cmd.upd_rd) begin
			rd_b_s1    <= mem[addr_b];
			wr_addr_s1 <= j_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_en_s1 <= 1'b0;
			sat_q    <= 1'b0;
		end else begin
			wr_en_s1 <= cmd.upd_rd;
			if (cmd.res_cap) begin
				sat_q <= 1'b0;
			end else if (wr_en_s1 && ovf) begin
				sat_q <= 1'b1;
			end
		end
	end

	generate
		if (COUNT_WIDTH > OUT_W) begin : g_clamp
			assign clamped = (|rd_a_s1[COUNT_WIDTH-1:OUT_W]) ? '1 : rd_a_s1[OUT_W-1:0];
		end else begin : g_extend
			assign clamped = OUT_W'(rd_a_s1);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.res_cap) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_cap) begin
			result_q.way_count       <= clamped;
			result_q.count_saturated <= sat_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

FILE: hw/rtl/subset_sum_way_counter.sv
// Subset-sum way counter: counts subsets of a streamed set that add up to target_sum.
// Top level joining the register file, controller and datapath. Depends on ssw_pkg.
//
// Usage:
//   Requests arrive on item/item_valid/item_stall, one set element each; the
//   element flagged last_item closes the set. Results leave on
//   result/result_valid/result_stall, one per set, carrying the way count for
//   the target and a sticky saturation flag.
//   target_sum is written over the APB port at byte address 0; write it only
//   while the block is idle.
//   Processing: an element of value v at or below the effective target t is
//   accepted, then the table memory gets one read-modify-write per entry from
//   t down to v; an element above t is only accepted. The single memory write
//   port paces this walk.
//   On the last element the target entry is read once the final table write
//   has landed (at once if the element was skipped) and loaded into the result
//   register, then a clearing sweep of all MAX_SUM + 1 entries restores the
//   table before the next request is taken. Reset starts the same sweep;
//   item_stall is high throughout. A stalled result stays in its register and
//   the block waits with it before clearing; register writes are taken at all times.
module subset_sum_way_counter
	import ssw_pkg::*;
#(
	parameter int MAX_SUM     = MAX_SUM_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [TARGET_W-1:0] target;
	cmd_t                cmd;
	sts_t                sts;

	ssw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.target  (target)
	);

	ssw_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last_item),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	ssw_dp #(
		.MAX_SUM     (MAX_SUM),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.target       (target),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

FILE: hw/rtl/ssw_checker.sv
// Port-level checks for the subset-sum way counter, bound to the top level.
// Depends on ssw_pkg and subset_sum_way_counter.
module ssw_checker
	import ssw_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               item_valid,
	input logic               item_stall,
	input item_t              item,
	input logic               result_valid,
	input logic               result_stall,
	input result_t            result
);

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result changed or dropped");

	// closing a set always makes the block busy on the next cycle
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.last_item |=> item_stall)
		else $error("block free right after last request");

	// a new result only appears while the block is clearing
	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_stall)
		else $error("result raised while requests are open");

endmodule

bind subset_sum_way_counter ssw_checker u_ssw_checker (.*);
